@@ rtl/core/ptrs_pkg.sv @@
// Package: types, codes and constants shared by the task release scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ptrs_pkg;

    localparam int TASK_COUNT = 7;
    localparam int IDX_W      = 3;
    localparam int CMD_W      = 2;
    localparam int PERIOD_W   = 16;
    localparam int PEND_W     = 8;
    localparam int MISSED_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command codes; the spare code behaves as a query
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // register map: period of task i at index i, then the pending limit
    localparam logic [CFG_IDX_W-1:0] REG_PENDING_LIMIT = 3'd7;

    localparam logic [PEND_W-1:0] PENDING_LIMIT_RESET = 8'd8;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] task_index;
    } req_t;

    typedef struct packed {
        logic                index_ok;
        logic                granted;
        logic [PEND_W-1:0]   pending_count;
        logic [MISSED_W-1:0] missed_count;
        logic [PERIOD_W-1:0] period_value;
    } res_t;

    // word moving along the cell chain
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] task_index;
        res_t             res;
    } tok_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic logic [PERIOD_W-1:0] period_reset(input logic [IDX_W-1:0] slot);
        logic [PERIOD_W-1:0] val;
        begin
            unique case (slot)
                3'd0, 3'd1: val = 16'd1;
                3'd2, 3'd3: val = 16'd5;
                3'd4:       val = 16'd10;
                3'd5, 3'd6: val = 16'd100;
                default:    val = 16'd1;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ptrs_cell.sv @@
// One task cell: holds a task's period, countdown, pending and missed counts.
`timescale 1ns / 1ps
`default_nettype none

module ptrs_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ptrs_pkg::IDX_W-1:0]  slot,
    input  wire logic [ptrs_pkg::PEND_W-1:0] pending_limit,
    input  wire ptrs_pkg::cfg_wr_t           cfg,
    input  wire logic                        in_valid,
    input  wire ptrs_pkg::tok_t              tok_in,
    output logic                             out_valid,
    output ptrs_pkg::tok_t                   tok_out
);
    import ptrs_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] countdown_reg, countdown_next;
    logic [PEND_W-1:0]   pending_reg, pending_next;
    logic [MISSED_W-1:0] missed_reg, missed_next;
    logic                valid_reg;
    tok_t                tok_reg, tok_next;
    logic                hit;
    logic                granted;

    assign hit = (tok_in.task_index == slot);

    always_comb
    begin
        period_next    = period_reg;
        countdown_next = countdown_reg;
        pending_next   = pending_reg;
        missed_next    = missed_reg;
        tok_next       = tok_in;
        granted        = 1'b0;

        if (cfg.we && cfg.index == slot)
        begin
            period_next    = cfg.data;
            countdown_next = cfg.data;
        end

        if (in_valid)
        begin
            case (tok_in.command)
                CMD_TICK:
                begin
                    if (countdown_reg > 16'd1)
                    begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                    else
                    begin
                        countdown_next = period_reg;
                        if (pending_reg != '0)
                        begin
                            missed_next = missed_reg + 32'd1;
                        end
                        if (pending_reg < pending_limit)
                        begin
                            pending_next = pending_reg + 8'd1;
                        end
                    end
                end
                CMD_TAKE:
                begin
                    if (hit && pending_reg != '0)
                    begin
                        pending_next = pending_reg - 8'd1;
                        granted      = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // addressed cell drops its post-operation state into the word
            if (hit)
            begin
                tok_next.res.index_ok      = 1'b1;
                tok_next.res.granted       = granted;
                tok_next.res.pending_count = pending_next;
                tok_next.res.missed_count  = missed_next;
                tok_next.res.period_value  = period_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= period_reset(slot);
            countdown_reg <= period_reset(slot);
            pending_reg   <= '0;
            missed_reg    <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
            missed_reg    <= missed_next;
            valid_reg     <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign tok_out   = tok_reg;

endmodule

`default_nettype wire

@@ rtl/core/periodic_task_release_scheduler.sv @@
// Top level: periodic task release scheduler built as a chain of task cells.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Command channel: a request word (command, task_index) is taken on a clock
//  edge with start high and busy low. Tick advances every task, take consumes
//  one pending release of the addressed task, query reads it back.
//  The word walks the chain of TASK_COUNT cells, one cell per cycle; each cell
//  applies the command to its own task and the addressed cell fills in the
//  result. The result appears on result with done high for exactly one
//  cycle, once the word has passed every cell register of the chain.
//  A new command is not taken while one is still in the chain; the next
//  command may be accepted in the cycle done is high.
//  The receiver cannot stall; each result is shown for one cycle only.
//  Config channel: cfg_index 0..6 writes a task period (and reloads its
//  countdown), index 7 writes the pending limit. Writes are taken while
//  busy and start are both low. Reset restores default periods, a pending
//  limit of 8 and clears all pending and missed counts; no clearing pass
//  is needed.
module periodic_task_release_scheduler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire ptrs_pkg::req_t                  request,
    output logic                                 done,
    output ptrs_pkg::res_t                       result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptrs_pkg::*;

    logic              accept;
    logic [PEND_W-1:0] pending_limit_reg;
    cfg_wr_t           cfg;
    logic              chain_valid [TASK_COUNT+1];
    tok_t              chain_tok   [TASK_COUNT+1];

    assign accept    = start && !busy;
    // a write never lands in the same cycle as a command entering the chain
    assign cfg_ready = !busy && !start;

    assign cfg.we    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_limit_reg <= PENDING_LIMIT_RESET;
        end
        else if (cfg.we && cfg.index == REG_PENDING_LIMIT)
        begin
            pending_limit_reg <= cfg_data[PEND_W-1:0];
        end
    end

    // word enters with an all-zero result: an invalid index matches no cell
    assign chain_valid[0] = accept;
    assign chain_tok[0]   = '{command: request.command, task_index: request.task_index,
                              res: '0};

    for (genvar k = 0; k < TASK_COUNT; k++)
    begin : g_cell
        ptrs_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .slot          (IDX_W'(k)),
            .pending_limit (pending_limit_reg),
            .cfg           (cfg),
            .in_valid      (chain_valid[k]),
            .tok_in        (chain_tok[k]),
            .out_valid     (chain_valid[k+1]),
            .tok_out       (chain_tok[k+1])
        );
    end

    // the last cell's output is the result slot, which frees the chain
    always_comb
    begin
        busy = 1'b0;
        for (int k = 1; k < TASK_COUNT; k++)
        begin
            busy = busy | chain_valid[k];
        end
    end

    assign done   = chain_valid[TASK_COUNT];
    assign result = chain_tok[TASK_COUNT].res;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TASK_COUNT))
        else $error("result without a command TASK_COUNT cycles earlier");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("chain idle right after accepting a command");

    a_granted_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.granted) |-> result.index_ok)
        else $error("grant reported for an invalid task");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.index_ok) |->
            (result.pending_count == '0 && result.missed_count == '0 &&
             result.period_value == '0))
        else $error("invalid task index returned nonzero fields");

    a_no_cfg_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg.we)
        else $error("config write taken while a command is in flight");

endmodule

`default_nettype wire

@@ sim/periodic_task_release_scheduler_tb.sv @@
// Testbench: drives the periodic task release scheduler and checks each result word.
`timescale 1ns / 1ps

module periodic_task_release_scheduler_tb;

    import ptrs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [IDX_W-1:0] NO_TASK   = 3'd7;
    localparam int SETTLE          = TASK_COUNT + 4;
    localparam int PHASES          = 5;
    localparam int WORDS_PER_PHASE = 326;
    localparam int OPENING_ROWS    = 22;
    localparam logic [TASK_COUNT*PERIOD_W-1:0] PERIOD_AT_RESET =
        {16'd100, 16'd100, 16'd10, 16'd5, 16'd5, 16'd1, 16'd1};
    localparam res_t BLANK = '0;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic             typed;
        res_t             want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    res_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // scheduler state as the testbench sees it
    logic [PERIOD_W-1:0] period_q    [TASK_COUNT];
    logic [PERIOD_W-1:0] countdown_q [TASK_COUNT];
    logic [PEND_W-1:0]   backlog_q   [TASK_COUNT];
    logic [MISSED_W-1:0] overrun_q   [TASK_COUNT];
    logic [PEND_W-1:0]   backlog_cap;

    res_t  reports_due [$];
    int    error_count;
    bit    force_want;
    res_t  forced_word;
    step_t opening [OPENING_ROWS];
    int    idle_mix [PHASES] = '{0, 86, 27, 0, 86};
    int    tick_mix [PHASES] = '{50, 85, 40, 55, 50};

    periodic_task_release_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic res_t report_of(input logic g, input logic [PEND_W-1:0] p,
                                       input logic [MISSED_W-1:0] m,
                                       input logic [PERIOD_W-1:0] per);
        res_t r;
        r.index_ok      = 1'b1;
        r.granted       = g;
        r.pending_count = p;
        r.missed_count  = m;
        r.period_value  = per;
        return r;
    endfunction

    // applies one command to the tracked state and returns the word it reports
    function automatic res_t apply_command(input req_t w);
        res_t r;
        logic ok;
        logic granted;
        int   t;
        r       = '0;
        ok      = (w.task_index < TASK_COUNT);
        granted = 1'b0;
        if (w.command == CMD_TICK)
        begin
            for (t = 0; t < TASK_COUNT; t++)
            begin
                if (countdown_q[t] > 1)
                    countdown_q[t] = countdown_q[t] - 1'b1;
                else
                begin
                    countdown_q[t] = period_q[t];
                    if (backlog_q[t] != 0)
                        overrun_q[t] = overrun_q[t] + 1'b1;
                    // a count already at or over the cap is left alone
                    if (backlog_q[t] < backlog_cap)
                        backlog_q[t] = backlog_q[t] + 1'b1;
                end
            end
        end
        else if (w.command == CMD_TAKE && ok && backlog_q[w.task_index] != 0)
        begin
            backlog_q[w.task_index] = backlog_q[w.task_index] - 1'b1;
            granted = 1'b1;
        end
        if (ok)
            r = report_of(granted, backlog_q[w.task_index], overrun_q[w.task_index],
                          period_q[w.task_index]);
        return r;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        if (idx < TASK_COUNT)
        begin
            period_q[idx]    = data;
            countdown_q[idx] = data;
        end
        else if (idx == REG_PENDING_LIMIT)
            backlog_cap = data[PEND_W-1:0];
    endfunction

    task automatic note_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_report(input res_t got);
        res_t want;
        if (reports_due.size() == 0)
        begin
            note_error($sformatf("result word %h with nothing outstanding", got));
            return;
        end
        want = reports_due.pop_front();
        if (got.index_ok !== want.index_ok)
            note_error($sformatf("index_ok %b, want %b", got.index_ok, want.index_ok));
        if (got.granted !== want.granted)
            note_error($sformatf("granted %b, want %b", got.granted, want.granted));
        if (got.pending_count !== want.pending_count)
            note_error($sformatf("pending_count %0d, want %0d",
                                 got.pending_count, want.pending_count));
        if (got.missed_count !== want.missed_count)
            note_error($sformatf("missed_count %0d, want %0d",
                                 got.missed_count, want.missed_count));
        if (got.period_value !== want.period_value)
            note_error($sformatf("period_value %0d, want %0d",
                                 got.period_value, want.period_value));
    endtask

    always @(posedge clk)
    begin : watch
        res_t predicted;
        if (rst_n)
        begin
            if (done)
                check_report(result);
            if (start && !busy)
            begin
                predicted = apply_command(request);
                reports_due.push_back(force_want ? forced_word : predicted);
            end
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input int idle_pct, input logic typed, input res_t want);
        req_t w;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        w.command    = cmd;
        w.task_index = idx;
        start       <= 1'b1;
        request     <= w;
        force_want   = typed;
        forced_word  = want;
        // busy is stable between edges, so look at it on the falling edge
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        int n;
        int r;
        int t;
        int roll;
        logic [PERIOD_W-1:0]   plan_period [TASK_COUNT];
        logic [CFG_DATA_W-1:0] plan_cap;
        logic [CMD_W-1:0]      cmd;
        logic [IDX_W-1:0]      idx;

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        force_want  = 1'b0;
        forced_word = '0;
        error_count = 0;
        for (t = 0; t < TASK_COUNT; t++)
        begin
            period_q[t]    = PERIOD_AT_RESET[t*PERIOD_W +: PERIOD_W];
            countdown_q[t] = PERIOD_AT_RESET[t*PERIOD_W +: PERIOD_W];
            backlog_q[t]   = '0;
            overrun_q[t]   = '0;
        end
        backlog_cap = PENDING_LIMIT_RESET;

        // from reset: tasks 0 and 1 release on every tick, 2 and 3 every fifth
        opening[0]  = '{CMD_QUERY, 3'd0,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd1)};
        opening[1]  = '{CMD_QUERY, NO_TASK, 1'b1, BLANK};
        opening[2]  = '{CMD_TAKE,  3'd0,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd1)};
        opening[3]  = '{CMD_TAKE,  NO_TASK, 1'b1, BLANK};
        opening[4]  = '{CMD_TICK,  3'd0,    1'b1, report_of(1'b0, 8'd1, 32'd0, 16'd1)};
        opening[5]  = '{CMD_TICK,  3'd1,    1'b1, report_of(1'b0, 8'd2, 32'd1, 16'd1)};
        opening[6]  = '{CMD_TAKE,  3'd1,    1'b1, report_of(1'b1, 8'd1, 32'd1, 16'd1)};
        opening[7]  = '{CMD_SPARE, 3'd2,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd5)};
        opening[8]  = '{CMD_TICK,  NO_TASK, 1'b1, BLANK};
        opening[9]  = '{CMD_TICK,  3'd2,    1'b0, BLANK};
        opening[10] = '{CMD_TICK,  3'd3,    1'b0, BLANK};
        opening[11] = '{CMD_TAKE,  3'd3,    1'b0, BLANK};
        opening[12] = '{CMD_TAKE,  3'd3,    1'b0, BLANK};
        opening[13] = '{CMD_QUERY, 3'd6,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd100)};
        opening[14] = '{CMD_QUERY, 3'd5,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd100)};
        opening[15] = '{CMD_QUERY, 3'd4,    1'b1, report_of(1'b0, 8'd0, 32'd0, 16'd10)};
        // task 0 runs into the pending cap
        opening[16] = '{CMD_TICK,  3'd0,    1'b0, BLANK};
        opening[17] = '{CMD_TICK,  3'd0,    1'b0, BLANK};
        opening[18] = '{CMD_TICK,  3'd0,    1'b0, BLANK};
        opening[19] = '{CMD_TICK,  3'd0,    1'b0, BLANK};
        opening[20] = '{CMD_SPARE, NO_TASK, 1'b1, BLANK};
        opening[21] = '{CMD_TAKE,  3'd6,    1'b0, BLANK};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < OPENING_ROWS; n++)
            send_word(opening[n].cmd, opening[n].idx, 0, opening[n].typed, opening[n].want);

        for (p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                drain_all();
                case (p)
                    1:
                    begin
                        plan_period = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd1, 16'd4};
                        plan_cap    = 16'h00FF;
                    end
                    2:
                    begin
                        for (t = 0; t < TASK_COUNT; t++)
                            plan_period[t] = PERIOD_W'($urandom_range(1, 9));
                        plan_cap = 16'hAB00;   // low byte zero: no new pending
                    end
                    3:
                    begin
                        for (t = 0; t < TASK_COUNT; t++)
                            plan_period[t] = PERIOD_W'($urandom_range(1, 6));
                        plan_cap = 16'h5A03;   // cap well under the counts left over
                    end
                    default:
                    begin
                        for (t = 0; t < TASK_COUNT; t++)
                            plan_period[t] = PERIOD_W'(($urandom_range(7) == 0)
                                                       ? $urandom : $urandom_range(0, 12));
                        plan_cap = CFG_DATA_W'($urandom);
                    end
                endcase
                for (r = 0; r <= REG_PENDING_LIMIT; r++)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= r[CFG_IDX_W-1:0];
                    cfg_data  <= (r < TASK_COUNT) ? plan_period[r] : plan_cap;
                    while (!cfg_ready)
                        @(negedge clk);
                    @(posedge clk);
                    @(negedge clk);
                end
                cfg_valid <= 1'b0;
                @(negedge clk);
            end

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n == WORDS_PER_PHASE / 2)
                    drain_all();
                roll = $urandom_range(99);
                if (roll < tick_mix[p])
                    cmd = CMD_TICK;
                else if (roll < tick_mix[p] + (100 - tick_mix[p]) * 2 / 3)
                    cmd = CMD_TAKE;
                else
                    cmd = ($urandom_range(3) == 0) ? CMD_SPARE : CMD_QUERY;
                idx = ($urandom_range(9) == 0) ? NO_TASK
                                               : IDX_W'($urandom_range(TASK_COUNT - 1));
                send_word(cmd, idx, idle_mix[p], 1'b0, BLANK);
            end
        end

        drain_all();
        if (error_count == 0 && reports_due.size() == 0)
            $display("periodic_task_release_scheduler_tb: clean");
        else
            $display("periodic_task_release_scheduler_tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("periodic_task_release_scheduler_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ptrs_pkg.sv
rtl/core/ptrs_cell.sv
rtl/core/periodic_task_release_scheduler.sv
sim/periodic_task_release_scheduler_tb.sv
